### hw/rtl/lpba_pkg.sv
// ----------------------------------------------------------------------------
// Lock pool bitmap allocator package
// Shared types, codes and helpers for the first-fit lock pool.
// ----------------------------------------------------------------------------
package lpba_pkg;

  localparam int POOL_DEPTH = 64;
  localparam int IDX_W      = $clog2(POOL_DEPTH);
  localparam int SIZE_W     = $clog2(POOL_DEPTH + 1);
  localparam int OPC_W      = 3;

  // request opcodes
  localparam logic [OPC_W-1:0] OP_ACQUIRE = 3'd0;
  localparam logic [OPC_W-1:0] OP_RELEASE = 3'd1;
  localparam logic [OPC_W-1:0] OP_FIND    = 3'd2;
  localparam logic [OPC_W-1:0] OP_REMOVE  = 3'd3;
  localparam logic [OPC_W-1:0] OP_RESIZE  = 3'd4;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NONE         = 2'd1,
    ST_ALREADY_FREE = 2'd2,
    ST_RANGE        = 2'd3
  } lpba_status_e;

  typedef enum logic [2:0] {
    K_ACQUIRE,
    K_RELEASE,
    K_FIND,
    K_REMOVE,
    K_RESIZE,
    K_NOP
  } lpba_kind_e;

  typedef struct packed {
    logic [OPC_W-1:0]  opcode;
    logic [IDX_W-1:0]  entry_index;
    logic [SIZE_W-1:0] new_size;
  } lpba_req_t;

  typedef struct packed {
    lpba_status_e      status;
    logic [IDX_W-1:0]  result_index;
    logic [SIZE_W-1:0] current_size;
  } lpba_rsp_t;

  // decoded command between front and back
  typedef struct packed {
    lpba_kind_e        kind;
    logic [IDX_W-1:0]  index;
    logic [SIZE_W-1:0] size;   // already saturated to POOL_DEPTH
  } lpba_cmd_t;

  // lowest set bit of a pool-wide vector
  function automatic logic [IDX_W-1:0] lowest_set(input logic [POOL_DEPTH-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = IDX_W'(i);
      end
    end
    return r;
  endfunction

  // bit i set where i < n
  function automatic logic [POOL_DEPTH-1:0] below_mask(input logic [SIZE_W-1:0] n);
    logic [POOL_DEPTH-1:0] m;
    for (int i = 0; i < POOL_DEPTH; i++) begin
      m[i] = (SIZE_W'(i) < n);
    end
    return m;
  endfunction

endpackage

### hw/rtl/lpba_fifo.sv
// ----------------------------------------------------------------------------
// Small synchronous queue
// Flop-based FIFO with push/full and pop/empty sides; DEPTH a power of two.
// ----------------------------------------------------------------------------
module lpba_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

### hw/rtl/lpba_front.sv
// ----------------------------------------------------------------------------
// Lock pool front end
// Accepts requests, decodes the opcode and saturates the resize value.
// ----------------------------------------------------------------------------
module lpba_front import lpba_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  lpba_req_t request,
  output logic      full,
  output logic      cmd_push,
  output lpba_cmd_t cmd,
  input  logic      cmd_full
);

  logic      vld;
  lpba_cmd_t decoded;

  always_comb begin
    decoded.index = request.entry_index;
    decoded.size  = (request.new_size > SIZE_W'(POOL_DEPTH)) ?
                    SIZE_W'(POOL_DEPTH) : request.new_size;
    unique case (request.opcode)
      OP_ACQUIRE: decoded.kind = K_ACQUIRE;
      OP_RELEASE: decoded.kind = K_RELEASE;
      OP_FIND:    decoded.kind = K_FIND;
      OP_REMOVE:  decoded.kind = K_REMOVE;
      OP_RESIZE:  decoded.kind = K_RESIZE;
      default:    decoded.kind = K_NOP;
    endcase
  end

  // stage frees when empty or when its item moves into the queue
  assign full     = vld && cmd_full;
  assign cmd_push = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (!full) begin
      vld <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      cmd <= decoded;
    end
  end

endmodule

### hw/rtl/lpba_back.sv
// ----------------------------------------------------------------------------
// Lock pool back end
// Holds free map and pool size; executes one command per cycle unless stalled.
// ----------------------------------------------------------------------------
module lpba_back import lpba_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_empty,
  input  lpba_cmd_t cmd,
  output logic      cmd_pop,
  output logic      rsp_push,
  output lpba_rsp_t rsp,
  input  logic      rsp_full
);

  logic [POOL_DEPTH-1:0] free_map;
  logic [POOL_DEPTH-1:0] free_map_next;
  logic [SIZE_W-1:0]     pool_size;
  logic [SIZE_W-1:0]     pool_size_next;

  logic                  go;
  logic [POOL_DEPTH-1:0] active;
  logic [POOL_DEPTH-1:0] avail;
  logic [POOL_DEPTH-1:0] busy;
  logic [IDX_W-1:0]      first_free;
  logic [IDX_W-1:0]      first_busy;
  logic                  in_range;
  logic [SIZE_W-1:0]     size_dec;
  logic [POOL_DEPTH-1:0] shifted;
  logic [POOL_DEPTH-1:0] removed;
  logic [POOL_DEPTH-1:0] idx_below;

  assign go       = !cmd_empty && !rsp_full;
  assign cmd_pop  = go;
  assign rsp_push = go;

  assign active     = below_mask(pool_size);
  assign avail      = free_map & active;
  assign busy       = ~free_map & active;
  assign first_free = lowest_set(avail);
  assign first_busy = lowest_set(busy);
  assign in_range   = ({1'b0, cmd.index} < pool_size);
  assign size_dec   = pool_size - 1'b1;
  assign shifted    = {1'b1, free_map[POOL_DEPTH-1:1]};
  assign idx_below  = below_mask({1'b0, cmd.index});

  // below idx keep, from idx take the next entry, vacated top held free
  always_comb begin
    for (int i = 0; i < POOL_DEPTH; i++) begin
      removed[i] = idx_below[i] ? free_map[i] : shifted[i];
    end
    removed = removed | ~below_mask(size_dec);
  end

  always_comb begin
    free_map_next       = free_map;
    pool_size_next      = pool_size;
    rsp.status          = ST_OK;
    rsp.result_index    = '0;
    unique case (cmd.kind)
      K_ACQUIRE: begin
        if (|avail) begin
          free_map_next[first_free] = 1'b0;
          rsp.result_index          = first_free;
        end else begin
          rsp.status = ST_NONE;
        end
      end
      K_RELEASE: begin
        if (!in_range) begin
          rsp.status = ST_RANGE;
        end else if (free_map[cmd.index]) begin
          rsp.status = ST_ALREADY_FREE;
        end else begin
          free_map_next[cmd.index] = 1'b1;
        end
      end
      K_FIND: begin
        if (|busy) begin
          rsp.result_index = first_busy;
        end else begin
          rsp.status = ST_NONE;
        end
      end
      K_REMOVE: begin
        if (!in_range) begin
          rsp.status = ST_RANGE;
        end else begin
          free_map_next  = removed;
          pool_size_next = size_dec;
        end
      end
      K_RESIZE: begin
        free_map_next  = free_map | ~below_mask(cmd.size);
        pool_size_next = cmd.size;
      end
      default: begin
      end
    endcase
    rsp.current_size = pool_size_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_map  <= '1;
      pool_size <= '0;
    end else if (go) begin
      free_map  <= free_map_next;
      pool_size <= pool_size_next;
    end
  end

endmodule

### hw/rtl/lock_pool_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// Lock pool bitmap allocator
// First-fit allocator over a pool of lock entries with resize and remove.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  request   push / full           lpba_req_t  (opcode, entry_index, new_size)
//  result    empty / pop           lpba_rsp_t  (status, result_index, current_size)
//
//  Sustained rate is one item per cycle while the result side is popped: the
//  back end resolves any operation on the flop bitmap combinationally.
//  An accepted item passes the front stage, command queue and result queue.
//  Reset (rst, synchronous) frees every entry and sets the pool size to zero.
//  Front and back stall on their own through a two-entry command queue; a
//  full result queue stalls the back end, then the front as commands back up.
// ----------------------------------------------------------------------------
module lock_pool_bitmap_allocator import lpba_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  // request side
  input  logic      push,
  input  lpba_req_t request,
  output logic      full,
  // result side
  output logic      empty,
  input  logic      pop,
  output lpba_rsp_t result
);

  localparam int CMD_W = $bits(lpba_cmd_t);
  localparam int RSP_W = $bits(lpba_rsp_t);

  logic      cmd_push;
  logic      cmd_full;
  logic      cmd_empty;
  logic      cmd_pop;
  lpba_cmd_t cmd_in;
  lpba_cmd_t cmd_out;
  logic      rsp_push;
  logic      rsp_full;
  lpba_rsp_t rsp_in;

  // decode stage
  lpba_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .request  (request),
    .full     (full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in),
    .cmd_full (cmd_full)
  );

  // decoupling queue between decode and execute
  lpba_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  // execute: free map and pool size live here
  lpba_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .rsp_push  (rsp_push),
    .rsp       (rsp_in),
    .rsp_full  (rsp_full)
  );

  // result queue: keeps execution going while the consumer holds off
  lpba_fifo #(
    .WIDTH (RSP_W),
    .DEPTH (2)
  ) u_rsp_q (
    .clk   (clk),
    .rst   (rst),
    .push  (rsp_push),
    .din   (rsp_in),
    .full  (rsp_full),
    .pop   (pop),
    .dout  (result),
    .empty (empty)
  );

endmodule

### hw/rtl/lpba_checker.sv
// ----------------------------------------------------------------------------
// Lock pool allocator port checker
// Port-level properties of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module lpba_checker import lpba_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      push,
  input lpba_req_t request,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input lpba_rsp_t result
);

  // nothing pending and room to take items straight after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not clear after reset");

  // a waiting result holds until popped
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("result changed while waiting");

  // failed operations report index zero
  a_idx_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && result.status != ST_OK |-> result.result_index == '0)
    else $error("non-zero index on failed operation");

  // pool size never beyond the pool
  a_size_cap: assert property (@(posedge clk) disable iff (rst)
    !empty |-> result.current_size <= SIZE_W'(POOL_DEPTH))
    else $error("pool size beyond pool depth");

  // a found entry other than zero lies below the reported size
  a_idx_in_pool: assert property (@(posedge clk) disable iff (rst)
    !empty && result.status == ST_OK && result.result_index != '0 |->
    {1'b0, result.result_index} < result.current_size)
    else $error("result index outside active pool");

endmodule

bind lock_pool_bitmap_allocator lpba_checker u_lpba_checker (.*);

### tb/sv/tb_lock_pool_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// Lock pool bitmap allocator testbench
// Drives request items through the push/full side and checks every result
// against a bit-true predictor of the first-fit pool: directed corner items
// first, then random traffic aimed at busy entries and small pools, under
// four sender/receiver idling profiles.
// ----------------------------------------------------------------------------
module tb_lock_pool_bitmap_allocator;
  import lpba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving either way
  localparam int ITEMS_PER_PHASE = 300;
  localparam int DRAIN_CYCLES = 8;       // margin for results still in flight

  // first opcode the block ignores; the spares run up to the top code
  localparam logic [OPC_W-1:0] OP_SPARE_FIRST = OP_RESIZE + 3'd1;

  // predictor state: one bit per entry (1 = free) and the active size
  typedef struct packed {
    logic [POOL_DEPTH-1:0] free;
    logic [SIZE_W-1:0]     size;
  } pool_state_t;

  logic      clk;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  lpba_req_t request = '0;
  logic      full;
  logic      empty;
  logic      pop = 1'b0;
  lpba_rsp_t result;

  lpba_req_t   pend_q[$];   // items waiting to be driven
  lpba_rsp_t   exp_q[$];    // predicted results, oldest first
  pool_state_t model_st;    // follows accepted items
  pool_state_t gen_st;      // follows generated items, steers the stimulus

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int total_cnt = 0;
  int acc_cnt = 0;
  int rsp_cnt = 0;
  int err_cnt = 0;
  int quiet_cycles = 0;
  bit req_taken = 1'b0;     // set at the rising edge, read by the driver
  bit rsp_taken = 1'b0;

  lock_pool_bitmap_allocator uut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .request (request),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Applies one item to a pool state and returns the result it gives.
  function automatic lpba_rsp_t pool_step(inout pool_state_t st, input lpba_req_t rq);
    lpba_rsp_t rs;
    logic      hit;
    rs.status = ST_OK;
    rs.result_index = '0;
    hit = 1'b0;
    case (rq.opcode)
      OP_ACQUIRE: begin
        // lowest free entry below the size
        for (int i = 0; i < POOL_DEPTH; i++) begin
          if (!hit && i < st.size && st.free[i]) begin
            hit = 1'b1;
            st.free[i] = 1'b0;
            rs.result_index = IDX_W'(i);
          end
        end
        if (!hit) begin
          rs.status = ST_NONE;
        end
      end
      OP_RELEASE: begin
        if (rq.entry_index >= st.size) begin
          rs.status = ST_RANGE;
        end else if (st.free[rq.entry_index]) begin
          rs.status = ST_ALREADY_FREE;
        end else begin
          st.free[rq.entry_index] = 1'b1;
        end
      end
      OP_FIND: begin
        for (int i = 0; i < POOL_DEPTH; i++) begin
          if (!hit && i < st.size && !st.free[i]) begin
            hit = 1'b1;
            rs.result_index = IDX_W'(i);
          end
        end
        if (!hit) begin
          rs.status = ST_NONE;
        end
      end
      OP_REMOVE: begin
        if (rq.entry_index >= st.size) begin
          rs.status = ST_RANGE;
        end else begin
          st.size = st.size - 1'b1;
          // ascending, so each entry takes its neighbour's old bit
          for (int i = 0; i < POOL_DEPTH - 1; i++) begin
            if (i >= rq.entry_index && i < st.size) begin
              st.free[i] = st.free[i+1];
            end
          end
          for (int i = 0; i < POOL_DEPTH; i++) begin
            if (i >= st.size) begin
              st.free[i] = 1'b1;
            end
          end
        end
      end
      OP_RESIZE: begin
        st.size = (rq.new_size > POOL_DEPTH) ? SIZE_W'(POOL_DEPTH) : rq.new_size;
        // shrinking frees the cut-off entries, busy or not
        for (int i = 0; i < POOL_DEPTH; i++) begin
          if (i >= st.size) begin
            st.free[i] = 1'b1;
          end
        end
      end
      default: begin
        // spare opcodes: no effect, plain ok
      end
    endcase
    rs.current_size = st.size;
    return rs;
  endfunction

  task automatic add_item(input logic [OPC_W-1:0] op, input int idx, input int sz);
    lpba_req_t rq;
    lpba_rsp_t unused_rsp;
    rq.opcode = op;
    rq.entry_index = IDX_W'(idx);
    rq.new_size = SIZE_W'(sz);
    unused_rsp = pool_step(gen_st, rq);
    pend_q.push_back(rq);
    total_cnt++;
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] result %0d: %s", $realtime, rsp_cnt, msg);
    err_cnt++;
  endtask

  // Corner items: empty pool, saturating resize, full pool, double free,
  // out-of-range index, remove with shift, shrink over busy entries,
  // spare opcodes.
  task automatic run_directed();
    add_item(OP_ACQUIRE, 0, 0);         // size 0: nothing to claim
    add_item(OP_FIND, 0, 0);            // nothing busy
    add_item(OP_RELEASE, 0, 0);         // out of range
    add_item(OP_REMOVE, 0, 0);          // out of range
    add_item(OP_RESIZE, 0, 127);        // saturates to the depth
    add_item(OP_RELEASE, 63, 0);        // top entry, already free
    add_item(OP_RESIZE, 0, 65);         // just over the depth
    add_item(OP_RESIZE, 0, 3);
    add_item(OP_ACQUIRE, 0, 0);
    add_item(OP_ACQUIRE, 0, 0);
    add_item(OP_ACQUIRE, 0, 0);
    add_item(OP_ACQUIRE, 0, 0);         // pool full
    add_item(OP_FIND, 0, 0);
    add_item(OP_RELEASE, 1, 0);
    add_item(OP_RELEASE, 1, 0);         // double free
    add_item(OP_REMOVE, 0, 0);          // busy entry 2 slides down to 1
    add_item(OP_FIND, 0, 0);
    add_item(OP_RELEASE, 2, 0);         // now above the size
    add_item(OP_RESIZE, 0, 1);          // cuts off a busy entry
    add_item(OP_FIND, 0, 0);
    for (int k = 0; k < 3; k++) begin
      add_item(OP_SPARE_FIRST + OPC_W'(k), 63, 127);
    end
    add_item(OP_RESIZE, 63, 64);
    add_item(OP_ACQUIRE, 63, 127);
    add_item(OP_REMOVE, 63, 0);         // remove the very last entry
  endtask

  // Random traffic that mostly makes sense for the current pool: releases
  // aim at busy entries, removes stay in range, resizes favour small pools
  // so that the pool runs full often.
  task automatic run_random(input int count);
    logic [OPC_W-1:0] op;
    int pick;
    int sel;
    int idx;
    int sz;
    int start;
    int j;
    bit found;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      idx = $urandom_range(POOL_DEPTH - 1);
      sz = $urandom_range(127);
      if (pick < 35) begin
        op = OP_ACQUIRE;
      end else if (pick < 60) begin
        op = OP_RELEASE;
        sel = $urandom_range(99);
        if (sel < 70) begin
          found = 1'b0;
          start = $urandom_range(POOL_DEPTH - 1);
          for (int k = 0; k < POOL_DEPTH; k++) begin
            j = (start + k) % POOL_DEPTH;
            if (!found && j < gen_st.size && !gen_st.free[j]) begin
              found = 1'b1;
              idx = j;
            end
          end
        end else if (sel < 85 && gen_st.size != 0) begin
          idx = $urandom_range(gen_st.size - 1);
        end
      end else if (pick < 70) begin
        op = OP_FIND;
      end else if (pick < 80) begin
        op = OP_REMOVE;
        if ($urandom_range(99) < 85 && gen_st.size != 0) begin
          idx = $urandom_range(gen_st.size - 1);
        end
      end else if (pick < 97) begin
        op = OP_RESIZE;
        sel = $urandom_range(99);
        if (sel < 50) begin
          sz = $urandom_range(8, 1);
        end else if (sel < 85) begin
          sz = $urandom_range(POOL_DEPTH);
        end else begin
          sz = $urandom_range(127, POOL_DEPTH + 1);
        end
      end else begin
        op = OP_SPARE_FIRST + OPC_W'($urandom_range(2));
      end
      add_item(op, idx, sz);
    end
  endtask

  // Driver: new item or hold at the falling edge, random pop.
  always @(negedge clk) begin
    if (!rst) begin
      if (!push || req_taken) begin
        if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          request <= pend_q.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predict on accepted requests, check accepted results, and
  // watch for a stalled block.
  always @(posedge clk) begin
    req_taken = 1'b0;
    rsp_taken = 1'b0;
    if (!rst) begin
      if (push && !full) begin
        req_taken = 1'b1;
        exp_q.push_back(pool_step(model_st, request));
        acc_cnt++;
      end
      if (pop && !empty) begin
        rsp_taken = 1'b1;
        if (exp_q.size() == 0) begin
          report_mismatch($sformatf("unexpected item, status %0d index %0d size %0d",
                                    result.status, result.result_index,
                                    result.current_size));
        end else begin
          lpba_rsp_t want;
          want = exp_q.pop_front();
          if (result.status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d",
                                      result.status, want.status));
          end
          if (result.result_index !== want.result_index) begin
            report_mismatch($sformatf("result_index %0d, expected %0d",
                                      result.result_index, want.result_index));
          end
          if (result.current_size !== want.current_size) begin
            report_mismatch($sformatf("current_size %0d, expected %0d",
                                      result.current_size, want.current_size));
          end
        end
        rsp_cnt++;
      end
    end
    if (req_taken || rsp_taken) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no item moved for %0d cycles", $realtime, quiet_cycles);
      $display("tb_lock_pool_bitmap_allocator failed");
      $finish;
    end
  end

  initial begin
    model_st.free = '1;
    model_st.size = '0;
    gen_st = model_st;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // idling profiles: none, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 57;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 57;
        end
        default: begin
          send_idle_pct = 24;
          recv_stall_pct = 24;
        end
      endcase
      if (ph == 0) begin
        run_directed();
      end
      run_random(ITEMS_PER_PHASE);
      while (acc_cnt != total_cnt) @(posedge clk);
    end

    while (exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_lock_pool_bitmap_allocator passed");
    end else begin
      $display("tb_lock_pool_bitmap_allocator failed");
    end
    $finish;
  end

endmodule
